>>> hw/rtl/lldp_tlv_walker_assert.svh
// Assertion macros used by the LLDP TLV walker RTL.
`ifndef LLDP_TLV_WALKER_ASSERT_SVH
`define LLDP_TLV_WALKER_ASSERT_SVH
`ifndef SYNTHESIS
// check under clock, masked while reset is high
`define LTW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// check under clock, also during reset
`define LTW_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define LTW_ASSERT(label, prop, msg)
`define LTW_ASSERT_RST(label, prop, msg)
`endif
`endif

>>> hw/rtl/lltw_pkg.sv
// Types and constants of the LLDP TLV walker.
`timescale 1ns / 1ps
package lltw_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int FLEN_W = 11;
   localparam int TYPE_W = 7;
   localparam int LEN_W  = 9;
   localparam int KIND_W = 2;

   // frame limit default
   localparam int unsigned MAX_FRAME_DEF = 2047;

   // TLV header facts
   localparam logic [FLEN_W-1:0] HDR_OCTETS    = FLEN_W'(2);
   localparam logic [TYPE_W-1:0] TYPE_END      = TYPE_W'(0);
   localparam logic [TYPE_W-1:0] KNOWN_LIMIT   = TYPE_W'(9);
   localparam logic [TYPE_W-1:0] TYPE_SYS_NAME = TYPE_W'(5);
   localparam logic [TYPE_W-1:0] TYPE_SYS_DESC = TYPE_W'(6);

   // event kinds
   localparam logic [KIND_W-1:0] EV_TLV  = 2'd0;
   localparam logic [KIND_W-1:0] EV_EOM  = 2'd1;
   localparam logic [KIND_W-1:0] EV_STOP = 2'd2;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int LVL_W     = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [TYPE_W-1:0] tlv_type;
      logic [LEN_W-1:0]  tlv_length;
      logic              known_type;
      logic              report_wanted;
      logic [FLEN_W-1:0] bytes_consumed;
      logic              last_of_run;
   } rsp_type;

   // write strobes into the result queue: b only together with a
   typedef struct packed {
      logic a;
      logic b;
   } push_type;

   // queue status toward the walker
   typedef struct packed {
      logic             room_two;
      logic [LVL_W-1:0] level;
   } fifo_stat_type;

endpackage

>>> hw/rtl/lltw_rsp_fifo.sv
// Small result queue: takes up to two words a cycle, gives one.
`timescale 1ns / 1ps
module lltw_rsp_fifo
   import lltw_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  push_type      push,
   input  rsp_type       data_a,
   input  rsp_type       data_b,
   output fifo_stat_type stat,
   output logic          out_valid,
   output rsp_type       out_data,
   input  logic          out_ready
);

   rsp_type          mem_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             pop;
   logic [PTR_W-1:0] wr_next;

   assign out_valid = (level_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign wr_next   = PTR_W'(wr_ptr_ff + 1'b1);

   assign stat.room_two = (level_ff <= LVL_W'(RSP_DEPTH - 2));
   assign stat.level    = level_ff;

   // pointer and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push.a && push.b) begin
         wr_ptr_in = PTR_W'(wr_ptr_ff + 2'd2);
      end else if (push.a) begin
         wr_ptr_in = wr_next;
      end
      if (pop) begin
         rd_ptr_in = PTR_W'(rd_ptr_ff + 1'b1);
      end
      level_in = LVL_W'(level_ff + LVL_W'(push.a) + LVL_W'(push.b) - LVL_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.a) begin
         mem_ff[wr_ptr_ff] <= data_a;
      end
      if (push.b) begin
         mem_ff[wr_next] <= data_b;
      end
   end

endmodule

>>> hw/rtl/lldp_tlv_walker.sv
// LLDP TLV walker top level: header tracking and result queue.
//
//  channel  dir  tdata                                   tuser        tlast
//  req      in   [7:0] data_byte, [18:8] frame_length    first_byte   -
//  rsp      out  [6:0] type, [15:7] length, [16] known,  event_kind   last_of_run
//                [17] report_wanted, [28:18] consumed
//
// A byte is held in an input register, then one pass of counter
// logic updates the walk state and writes one or two results into a four
// word queue. One byte per cycle is taken while the queue has room for two.
// The results of a byte pass the input register and then the queue.
// Reset clears the walk (waiting for a frame) and empties the queue.
// A stalled result side fills the queue; the req side then stalls too.
`timescale 1ns / 1ps
`include "lldp_tlv_walker_assert.svh"
module lldp_tlv_walker
   import lltw_pkg::*;
#(
   parameter int unsigned MAX_FRAME = MAX_FRAME_DEF
)(
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_byte, [18:8] frame_length, rest zero
   input  logic        req_tuser,   // [0] first_byte
   // result side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [6:0] tlv_type, [15:7] tlv_length, [16] known_type,
                                    // [17] report_wanted, [28:18] bytes_consumed, rest zero
   output logic [1:0]  rsp_tuser,   // [1:0] event_kind
   output logic        rsp_tlast    // last_of_run
);

   // walk phases
   localparam logic [1:0] PH_DONE    = 2'd0;
   localparam logic [1:0] PH_HEAD_HI = 2'd1;
   localparam logic [1:0] PH_HEAD_LO = 2'd2;
   localparam logic [1:0] PH_VALUE   = 2'd3;

   // input register
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_first_ff;
   logic [FLEN_W-1:0] in_flen_ff;

   // walk state
   logic [1:0]        phase_ff, phase_in;
   logic [BYTE_W-1:0] hdr_hi_ff, hdr_hi_in;
   logic [LEN_W-1:0]  val_rem_ff, val_rem_in;
   logic [FLEN_W-1:0] left_ff, left_in;
   logic [FLEN_W-1:0] used_ff, used_in;

   logic          req_accept;
   logic          advance;
   push_type      push;
   rsp_type       res_a, res_b;
   fifo_stat_type fifo_stat;
   rsp_type       out_word;

   assign advance    = in_valid_ff && fifo_stat.room_two;
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   // input register load
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_tdata[7:0];
         in_flen_ff  <= req_tdata[18:8];
         in_first_ff <= req_tuser;
      end
   end

   // one pass of the walk for the held byte
   always_comb begin
      logic [FLEN_W-1:0] flen_sat;
      logic [TYPE_W-1:0] hdr_type;
      logic [LEN_W-1:0]  hdr_len;
      logic [FLEN_W:0]   tlv_total;
      logic              stopped;

      phase_in   = phase_ff;
      hdr_hi_in  = hdr_hi_ff;
      val_rem_in = val_rem_ff;
      left_in    = left_ff;
      used_in    = used_ff;
      push       = '0;
      res_a      = '0;
      res_b      = '0;
      stopped    = 1'b0;
      flen_sat   = in_flen_ff;
      hdr_type   = hdr_hi_ff[7:1];
      hdr_len    = {hdr_hi_ff[0], in_byte_ff};
      tlv_total  = (FLEN_W+1)'(hdr_len) + (FLEN_W+1)'(HDR_OCTETS);

      // new frame restarts the walk
      if (in_first_ff) begin
         if (int'(in_flen_ff) > MAX_FRAME) begin
            flen_sat = FLEN_W'(MAX_FRAME);
         end
         left_in    = flen_sat;
         used_in    = '0;
         val_rem_in = '0;
         hdr_hi_in  = '0;
         phase_in   = PH_HEAD_HI;
         if (flen_sat < HDR_OCTETS) begin
            push.a               = 1'b1;
            res_a.event_kind     = EV_STOP;
            res_a.bytes_consumed = '0;
            phase_in             = PH_DONE;
            stopped              = 1'b1;
         end
      end

      if (!stopped) begin
         unique case (phase_in)
            PH_DONE: begin
            end
            PH_HEAD_HI: begin
               hdr_hi_in = in_byte_ff;
               phase_in  = PH_HEAD_LO;
            end
            PH_HEAD_LO: begin
               push.a = 1'b1;
               if (tlv_total > (FLEN_W+1)'(left_in)) begin
                  // TLV would overrun the frame
                  res_a.event_kind     = EV_STOP;
                  res_a.bytes_consumed = used_in;
                  phase_in             = PH_DONE;
               end else if (hdr_type == TYPE_END) begin
                  used_in              = FLEN_W'(used_in + HDR_OCTETS);
                  res_a.event_kind     = EV_EOM;
                  res_a.tlv_type       = hdr_type;
                  res_a.tlv_length     = hdr_len;
                  res_a.known_type     = 1'b1;
                  res_a.bytes_consumed = used_in;
                  phase_in             = PH_DONE;
               end else begin
                  left_in              = FLEN_W'(left_in - tlv_total);
                  used_in              = FLEN_W'(used_in + tlv_total);
                  res_a.event_kind     = EV_TLV;
                  res_a.tlv_type       = hdr_type;
                  res_a.tlv_length     = hdr_len;
                  res_a.known_type     = (hdr_type < KNOWN_LIMIT);
                  res_a.report_wanted  = (hdr_type == TYPE_SYS_NAME) ||
                                         (hdr_type == TYPE_SYS_DESC);
                  res_a.bytes_consumed = used_in;
                  if (hdr_len != '0) begin
                     val_rem_in = hdr_len;
                     phase_in   = PH_VALUE;
                  end else if (left_in < HDR_OCTETS) begin
                     // empty TLV left too little for another header
                     push.b               = 1'b1;
                     res_b.event_kind     = EV_STOP;
                     res_b.bytes_consumed = used_in;
                     phase_in             = PH_DONE;
                  end else begin
                     phase_in = PH_HEAD_HI;
                  end
               end
            end
            PH_VALUE: begin
               if (val_rem_in != '0) begin
                  val_rem_in = LEN_W'(val_rem_in - 1'b1);
               end
               if (val_rem_in == '0) begin
                  if (left_in < HDR_OCTETS) begin
                     push.a               = 1'b1;
                     res_a.event_kind     = EV_STOP;
                     res_a.bytes_consumed = used_in;
                     phase_in             = PH_DONE;
                  end else begin
                     phase_in = PH_HEAD_HI;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // mark the final word of this byte
      if (push.b) begin
         res_b.last_of_run = 1'b1;
      end else begin
         res_a.last_of_run = 1'b1;
      end

      // nothing moves unless the byte is taken this cycle
      if (!advance) begin
         phase_in   = phase_ff;
         hdr_hi_in  = hdr_hi_ff;
         val_rem_in = val_rem_ff;
         left_in    = left_ff;
         used_in    = used_ff;
         push       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_DONE;
         hdr_hi_ff  <= '0;
         val_rem_ff <= '0;
         left_ff    <= '0;
         used_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         hdr_hi_ff  <= hdr_hi_in;
         val_rem_ff <= val_rem_in;
         left_ff    <= left_in;
         used_ff    <= used_in;
      end
   end

   // result queue
   lltw_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_a    (res_a),
      .data_b    (res_b),
      .stat      (fifo_stat),
      .out_valid (rsp_tvalid),
      .out_data  (out_word),
      .out_ready (rsp_tready)
   );

   // pack the result word
   assign rsp_tdata = {3'b000, out_word.bytes_consumed, out_word.report_wanted,
                       out_word.known_type, out_word.tlv_length, out_word.tlv_type};
   assign rsp_tuser = out_word.event_kind;
   assign rsp_tlast = out_word.last_of_run;

   // checks
   `LTW_ASSERT(a_level_max, fifo_stat.level <= LVL_W'(RSP_DEPTH), "result queue overfilled")
   `LTW_ASSERT(a_push_shows, push.a |=> rsp_tvalid, "written result not offered")
   `LTW_ASSERT(a_done_quiet, (phase_ff == PH_DONE && !in_first_ff) |-> !push.a, "word while idle")
   `LTW_ASSERT(a_pair_order, push.b |-> push.a && res_b.event_kind == EV_STOP, "bad pair")
   `LTW_ASSERT_RST(a_reset_empty, reset |=> !rsp_tvalid, "result offered after reset")

endmodule
